// ===== rtl/br1d_pkg.sv =====
`default_nettype none

package br1d_pkg;

    typedef enum logic [3:0] {
        PH_CONTROL = 4'b0001,
        PH_LITERAL = 4'b0010,
        PH_REPEAT  = 4'b0100,
        PH_STOPPED = 4'b1000
    } t_phase;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_RUN    = 2'd1;
    localparam logic [1:0] ERR_SHORT  = 2'd2;
    localparam logic [1:0] ERR_CONFIG = 2'd3;

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_PLANES = 2'd1;
    localparam logic [1:0] CFG_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_HEIGHT = 2'd3;

    localparam logic [7:0]  MODE_RAW       = 8'd0;
    localparam logic [7:0]  MODE_BYTERUN1  = 8'd1;
    localparam logic [7:0]  MODE_RST       = 8'd1;
    localparam logic [7:0]  PLANES_RST     = 8'd4;
    localparam logic [15:0] WIDTH_RST      = 16'd320;
    localparam logic [15:0] HEIGHT_RST     = 16'd200;

    localparam logic [7:0] CTRL_NOOP = 8'h80;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       last;
        logic [7:0] ctrl_cnt;
        logic       is_noop;
        logic       is_rep;
    } t_item;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] run_length;
        logic       final_res;
        logic [1:0] status;
    } t_result;

    typedef struct packed {
        logic ok;
        logic raw;
    } t_cfg_flags;

endpackage

`default_nettype wire

// ===== rtl/br1d_fifo.sv =====
`default_nettype none

module br1d_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_rdata,
    output logic                  o_full,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/br1d_front.sv =====
`default_nettype none

module br1d_front
    import br1d_pkg::*;
(
    input  wire logic       i_push,
    input  wire logic [7:0] i_body_byte,
    input  wire logic       i_last,
    input  wire logic       i_q_full,
    output logic            o_full,
    output logic            o_q_push,
    output t_item           o_item
);

    // A control byte n gives n+1 literals or a run of 1-n bytes, both modulo 256.
    always_comb begin
        o_item.body_byte = i_body_byte;
        o_item.last      = i_last;
        o_item.ctrl_cnt  = i_body_byte[7] ? (8'd1 - i_body_byte) : (i_body_byte + 8'd1);
        o_item.is_noop   = (i_body_byte == CTRL_NOOP);
        o_item.is_rep    = i_body_byte[7] && (i_body_byte != CTRL_NOOP);
    end

    assign o_full   = i_q_full;
    assign o_q_push = i_push && !i_q_full;

endmodule

`default_nettype wire

// ===== rtl/br1d_back.sv =====
`default_nettype none

module br1d_back
    import br1d_pkg::*;
#(
    parameter int CW = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_item         i_item,
    input  wire logic          i_item_valid,
    output logic               o_item_pop,
    input  wire t_cfg_flags    i_cfg,
    input  wire logic [CW-1:0] i_expect,
    input  wire logic          i_res_full,
    output logic               o_res_push,
    output t_result            o_res
);

    localparam int WW = (CW > 8) ? CW : 8;

    t_phase        r_phase;
    t_phase        n_phase;
    logic [7:0]    r_run_left;
    logic [7:0]    n_run_left;
    logic [CW-1:0] r_bw;
    logic [CW-1:0] n_bw;
    logic [1:0]    r_err;
    logic [1:0]    n_err;

    logic [CW-1:0] room;
    logic [CW-1:0] bw_inc;
    logic [WW-1:0] rep_len;
    logic [7:0]    val;
    logic [7:0]    len;
    logic [1:0]    status;
    logic          raised;
    logic          do_step;

    always_comb begin
        n_phase    = r_phase;
        n_run_left = r_run_left;
        n_bw       = r_bw;
        n_err      = r_err;
        val        = '0;
        len        = '0;
        status     = ERR_NONE;
        raised     = 1'b0;
        room       = (r_bw >= i_expect) ? '0 : i_expect - r_bw;
        bw_inc     = r_bw + CW'(1);
        rep_len    = (WW'(r_run_left) > WW'(room)) ? WW'(room) : WW'(r_run_left);

        if (r_err == ERR_NONE && r_phase != PH_STOPPED) begin
            if (!i_cfg.ok) begin
                n_err   = ERR_CONFIG;
                n_phase = PH_STOPPED;
                raised  = 1'b1;
            end else if (room == '0) begin
                n_phase = PH_STOPPED;
            end else if (i_cfg.raw) begin
                val  = i_item.body_byte;
                len  = 8'd1;
                n_bw = bw_inc;
                if (bw_inc >= i_expect) begin
                    n_phase = PH_STOPPED;
                end
            end else begin
                case (r_phase)
                    PH_CONTROL: begin
                        if (!i_item.is_noop) begin
                            if (WW'(i_item.ctrl_cnt) > WW'(room)) begin
                                n_err   = ERR_RUN;
                                n_phase = PH_STOPPED;
                                raised  = 1'b1;
                            end else begin
                                n_run_left = i_item.ctrl_cnt;
                                n_phase    = i_item.is_rep ? PH_REPEAT : PH_LITERAL;
                            end
                        end
                    end
                    PH_LITERAL: begin
                        val        = i_item.body_byte;
                        len        = 8'd1;
                        n_bw       = bw_inc;
                        n_run_left = (r_run_left != '0) ? r_run_left - 8'd1 : '0;
                        if (n_run_left == '0) begin
                            n_phase = PH_CONTROL;
                        end
                        if (bw_inc >= i_expect) begin
                            n_phase = PH_STOPPED;
                        end
                    end
                    PH_REPEAT: begin
                        val        = i_item.body_byte;
                        len        = rep_len[7:0];
                        n_bw       = r_bw + rep_len[CW-1:0];
                        n_run_left = '0;
                        n_phase    = (n_bw >= i_expect) ? PH_STOPPED : PH_CONTROL;
                    end
                    default: begin
                        n_phase = PH_STOPPED;
                    end
                endcase
            end
        end

        if (i_item.last) begin
            if (n_err == ERR_NONE && !i_cfg.raw &&
                (n_phase == PH_LITERAL || n_phase == PH_REPEAT)) begin
                n_err  = ERR_RUN;
                raised = 1'b1;
            end
            if (n_err != ERR_NONE) begin
                status = n_err;
            end else if (!i_cfg.ok) begin
                status = ERR_CONFIG;
            end else if (n_bw != i_expect) begin
                status = ERR_SHORT;
            end else begin
                status = ERR_NONE;
            end
        end

        if (raised) begin
            val = '0;
            len = '0;
        end
    end

    assign do_step    = i_item_valid && !i_res_full;
    assign o_item_pop = do_step;
    assign o_res_push = do_step && ((len != '0) || i_item.last);

    always_comb begin
        o_res.data_byte  = val;
        o_res.run_length = len;
        o_res.final_res  = i_item.last;
        o_res.status     = status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_CONTROL;
            r_run_left <= '0;
            r_bw       <= '0;
            r_err      <= ERR_NONE;
        end else if (do_step) begin
            if (i_item.last) begin
                r_phase    <= PH_CONTROL;
                r_run_left <= '0;
                r_bw       <= '0;
                r_err      <= ERR_NONE;
            end else begin
                r_phase    <= n_phase;
                r_run_left <= n_run_left;
                r_bw       <= n_bw;
                r_err      <= n_err;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/byterun1_body_decoder.sv =====
// Byte-serial ByteRun1 (PackBits) body decoder.
// The input channel takes one body byte per transaction (push while full is
// low), with i_last set on the final byte of a body. The result channel
// offers the oldest result while empty is low; pop takes it. A result is a
// decoded byte with a repeat count (a literal has count 1, a run up to 128),
// and the byte flagged last always yields a result carrying the final status.
// Control bytes and ignored bytes yield no result unless flagged last.
// Configuration registers (mode, plane count, width, height) are written
// through i_cfg_we/i_cfg_index/i_cfg_data; the user is to write them only
// while no transaction is pending, which the block does not enforce.
// Throughput is one byte per cycle while the result queue is not full. A
// byte is registered in the input queue, decoded combinationally in the
// decode stage, and its result is registered in the result queue before
// it reaches the result ports. A stalled receiver fills the result queue,
// which halts the decode stage, then fills the input queue and raises full.
// Synchronous reset empties both queues, clears the decode state and loads
// the default configuration (ByteRun1, 4 planes, 320 by 200).

`default_nettype none

module byterun1_body_decoder
    import br1d_pkg::*;
#(
    parameter int SCREEN_WIDTH    = 320,
    parameter int SCREEN_HEIGHT   = 200,
    parameter int MAX_PLANE_COUNT = 8,
    parameter int QUEUE_DEPTH     = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_body_byte,
    input  wire logic        i_last,
    output logic             empty,
    input  wire logic        pop,
    output logic      [7:0]  o_data_byte,
    output logic      [7:0]  o_run_length,
    output logic             o_final_res,
    output logic      [1:0]  o_status
);

    localparam int ROW_BYTES   = ((SCREEN_WIDTH + 15) >> 4) * 2;
    localparam int PLANE_BYTES = ROW_BYTES * SCREEN_HEIGHT;
    localparam int MAX_BYTES   = PLANE_BYTES * MAX_PLANE_COUNT;
    localparam int CW          = $clog2(MAX_BYTES + 1);
    localparam int PW          = $clog2(MAX_PLANE_COUNT + 1);

    logic [7:0]    r_mode;
    logic [7:0]    r_planes;
    logic [15:0]   r_width;
    logic [15:0]   r_height;
    t_cfg_flags    r_cfg;
    logic [CW-1:0] r_expect;

    t_item   item_in;
    t_item   item_out;
    logic    q_push;
    logic    q_full;
    logic    q_empty;
    logic    q_pop;
    t_result res_in;
    t_result res_out;
    logic    res_push;
    logic    res_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_RST;
            r_planes <= PLANES_RST;
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODE:   r_mode   <= i_cfg_data[7:0];
                CFG_PLANES: r_planes <= i_cfg_data[7:0];
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                default:    r_mode   <= r_mode;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_cfg.ok  <= (r_mode == MODE_RAW || r_mode == MODE_BYTERUN1) &&
                     (r_planes != 8'd0) && (r_planes <= 8'(MAX_PLANE_COUNT)) &&
                     (r_width == 16'(SCREEN_WIDTH)) && (r_height == 16'(SCREEN_HEIGHT));
        r_cfg.raw <= (r_mode == MODE_RAW);
        r_expect  <= CW'(PLANE_BYTES) * CW'(r_planes[PW-1:0]);
    end

    br1d_front u_front (
        .i_push      (push),
        .i_body_byte (i_body_byte),
        .i_last      (i_last),
        .i_q_full    (q_full),
        .o_full      (full),
        .o_q_push    (q_push),
        .o_item      (item_in)
    );

    br1d_fifo #(
        .WIDTH ($bits(t_item)),
        .DEPTH (QUEUE_DEPTH)
    ) u_item_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (item_in),
        .i_pop   (q_pop),
        .o_rdata (item_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    br1d_back #(
        .CW (CW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item_out),
        .i_item_valid (!q_empty),
        .o_item_pop   (q_pop),
        .i_cfg        (r_cfg),
        .i_expect     (r_expect),
        .i_res_full   (res_full),
        .o_res_push   (res_push),
        .o_res        (res_in)
    );

    br1d_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (res_in),
        .i_pop   (pop),
        .o_rdata (res_out),
        .o_full  (res_full),
        .o_empty (empty)
    );

    assign o_data_byte  = res_out.data_byte;
    assign o_run_length = res_out.run_length;
    assign o_final_res  = res_out.final_res;
    assign o_status     = res_out.status;

`ifndef SYNTH
    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("Result pushed into a full result queue.");

    a_empty_result_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_run_length != 8'd0 || o_final_res))
        else $error("Result without data that is not the final result.");

    a_status_only_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_final_res) |-> (o_status == ERR_NONE))
        else $error("Nonzero status on a result that is not final.");

    a_no_data_after_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_run_length == 8'd0) |-> (o_data_byte == 8'd0))
        else $error("Result without data carries a data byte.");
`endif

endmodule

`default_nettype wire
